### hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // one request on the input side
    typedef struct packed {
        logic [7:0] in_byte;
        logic       input_ended;
    } in_t;

    // one result on the output side
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic [2:0] status;
    } out_t;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_EXP_BS = 3'd3,
        MODE_EXP_U  = 3'd4
    } mode_t;

    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_ENDED   = 3'd3;
    localparam logic [2:0] ST_UNICODE = 3'd4;

endpackage

### hw/rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder state and the per-byte decode logic for one request.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  jsu_pkg::in_t  req,
    output jsu_pkg::out_t result
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    hex_reg, hex_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           hs_reg, hs_next;

    logic [3:0]     nibble;
    logic           nibble_ok;
    logic [15:0]    hex_shift;
    logic           is_high, is_low, is_ascii;

    always_comb begin
        nibble    = 4'd0;
        nibble_ok = 1'b1;
        if (req.in_byte >= 8'h30 && req.in_byte <= 8'h39) begin
            nibble = req.in_byte[3:0];
        end else if ((req.in_byte >= 8'h41 && req.in_byte <= 8'h46) ||
                     (req.in_byte >= 8'h61 && req.in_byte <= 8'h66)) begin
            nibble = req.in_byte[3:0] + 4'd9;
        end else begin
            nibble_ok = 1'b0;
        end
    end

    assign hex_shift = {hex_reg[11:0], nibble};
    assign is_high   = (hex_shift[15:10] == 6'b110110);
    assign is_low    = (hex_shift[15:10] == 6'b110111);
    assign is_ascii  = (hex_shift[15:7] == 9'd0);

    always_comb begin
        mode_next         = mode_reg;
        hex_next          = hex_reg;
        cnt_next          = cnt_reg;
        hs_next           = hs_reg;
        result.out_char   = 8'd0;
        result.char_valid = 1'b0;
        result.status     = jsu_pkg::ST_BUSY;

        if (req.input_ended) begin
            result.status = jsu_pkg::ST_ENDED;
        end else begin
            unique case (mode_reg)
                jsu_pkg::MODE_ESC: begin
                    case (req.in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: begin
                            result.out_char   = req.in_byte;
                            result.char_valid = 1'b1;
                        end
                        CH_B: begin
                            result.out_char   = 8'h08;
                            result.char_valid = 1'b1;
                        end
                        CH_F: begin
                            result.out_char   = 8'h0C;
                            result.char_valid = 1'b1;
                        end
                        CH_N: begin
                            result.out_char   = 8'h0A;
                            result.char_valid = 1'b1;
                        end
                        CH_R: begin
                            result.out_char   = 8'h0D;
                            result.char_valid = 1'b1;
                        end
                        CH_T: begin
                            result.out_char   = 8'h09;
                            result.char_valid = 1'b1;
                        end
                        CH_U: begin
                            mode_next = jsu_pkg::MODE_HEX;
                            hex_next  = 16'd0;
                            cnt_next  = 2'd0;
                        end
                        default: begin
                            result.status = jsu_pkg::ST_INVALID;
                        end
                    endcase
                    if (result.char_valid) begin
                        mode_next = jsu_pkg::MODE_PLAIN;
                    end
                end
                jsu_pkg::MODE_HEX: begin
                    if (!nibble_ok) begin
                        result.status = jsu_pkg::ST_INVALID;
                    end else begin
                        hex_next = hex_shift;
                        if (cnt_reg != 2'd3) begin
                            cnt_next = cnt_reg + 2'd1;
                        end else begin
                            cnt_next = 2'd0;
                            if (hs_reg) begin
                                // second half of a pair: always outside ascii
                                result.status = is_low ? jsu_pkg::ST_UNICODE
                                                       : jsu_pkg::ST_INVALID;
                            end else if (is_high) begin
                                hs_next   = 1'b1;
                                mode_next = jsu_pkg::MODE_EXP_BS;
                            end else if (is_ascii) begin
                                result.out_char   = hex_shift[7:0];
                                result.char_valid = 1'b1;
                                mode_next         = jsu_pkg::MODE_PLAIN;
                                hex_next          = 16'd0;
                            end else begin
                                result.status = jsu_pkg::ST_UNICODE;
                            end
                        end
                    end
                end
                jsu_pkg::MODE_EXP_BS: begin
                    if (req.in_byte == CH_BSL) begin
                        mode_next = jsu_pkg::MODE_EXP_U;
                    end else begin
                        result.status = jsu_pkg::ST_INVALID;
                    end
                end
                jsu_pkg::MODE_EXP_U: begin
                    if (req.in_byte == CH_U) begin
                        mode_next = jsu_pkg::MODE_HEX;
                        hex_next  = 16'd0;
                        cnt_next  = 2'd0;
                    end else begin
                        result.status = jsu_pkg::ST_INVALID;
                    end
                end
                default: begin
                    if (req.in_byte == CH_QUOTE) begin
                        result.status = jsu_pkg::ST_CLOSED;
                    end else if (req.in_byte == CH_BSL) begin
                        mode_next = jsu_pkg::MODE_ESC;
                    end else if (req.in_byte < CH_SPACE) begin
                        result.status = jsu_pkg::ST_INVALID;
                    end else begin
                        result.out_char   = req.in_byte;
                        result.char_valid = 1'b1;
                        mode_next         = jsu_pkg::MODE_PLAIN;
                    end
                end
            endcase
        end

        // string done or broken: start over
        if (result.status != jsu_pkg::ST_BUSY) begin
            mode_next = jsu_pkg::MODE_PLAIN;
            hex_next  = 16'd0;
            cnt_next  = 2'd0;
            hs_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= jsu_pkg::MODE_PLAIN;
            hex_reg  <= 16'd0;
            cnt_reg  <= 2'd0;
            hs_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cnt_reg  <= cnt_next;
            hs_reg   <= hs_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result.status != jsu_pkg::ST_BUSY |=>
            mode_reg == jsu_pkg::MODE_PLAIN && cnt_reg == 2'd0 && !hs_reg)
        else $error("decoder state not cleared after end of string");

    a_hs_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        hs_reg |-> mode_reg == jsu_pkg::MODE_HEX || mode_reg == jsu_pkg::MODE_EXP_BS ||
                   mode_reg == jsu_pkg::MODE_EXP_U)
        else $error("surrogate flag set outside unicode escape");

    a_cnt_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd0 |-> mode_reg == jsu_pkg::MODE_HEX)
        else $error("hex digit count set outside hex mode");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(mode_reg) && $stable(cnt_reg) && $stable(hs_reg))
        else $error("decoder state moved without a request");
`endif

endmodule

### hw/rtl/jsu_out_stage.sv
// ----------------------------------------------------------------------------
// jsu_out_stage
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
module jsu_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  jsu_pkg::out_t result,
    output logic          load_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output jsu_pkg::out_t m_data
);

    logic          valid_reg, valid_next;
    jsu_pkg::out_t data_reg;

    // register frees up in the same cycle the receiver takes it
    assign load_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !load)
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.char_valid |-> data_reg.status == jsu_pkg::ST_BUSY)
        else $error("character reported together with an end status");
`endif

endmodule

### hw/rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes the body of a JSON string, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one byte of the string body after the
//   opening quote, or an end-of-input marker (input_ended set).
//   m_valid/m_ready/m_data carry exactly one result per request: a decoded
//   character when char_valid is set, and a status (in progress, closed,
//   invalid, ended early, non-ascii unicode).
//   The result is registered: a taken request shows its result on m_data
//   in the next cycle. One request is taken every cycle while the
//   receiver keeps m_ready high; the single result register sets this.
//   When the receiver stalls, the result is held and s_ready drops until
//   it is taken; s_ready comes back in the same cycle that m_ready is seen.
//   Reset (aresetn low at a clock edge) returns the decoder to plain
//   character mode and empties the result register.
//   After a closed string or any error the next byte starts a new string.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jsu_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output jsu_pkg::out_t m_data
);

    logic          accept;
    jsu_pkg::out_t result;

    assign accept = s_valid && s_ready;

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_data),
        .result  (result)
    );

    jsu_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .result     (result),
        .load_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
